@@ rtl/indexed_min_heap_unit_assert.svh @@
// Assertion macros for the indexed min-heap unit.
// Used by rtl/indexed_min_heap_unit.sv; no other dependencies.
`ifndef INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`ifndef SYNTH
`define IMH_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define IMH_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define IMH_ASSERT_IMPL(label, clk, rstn, prop)
`define IMH_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

@@ rtl/imh_pkg.sv @@
// Package for the indexed min-heap unit: widths, command and status codes, states.
// No dependencies.
package imh_pkg;
    localparam int Capacity   = 256;
    localparam int PrioBits   = 31;
    localparam int KeyBits    = 8;
    localparam int NumKeys    = 256;
    localparam int SlotBits   = $clog2(Capacity);
    localparam int CountBits  = $clog2(Capacity + 1);

    typedef logic [PrioBits-1:0]  prio_t;
    typedef logic [KeyBits-1:0]   key_t;
    typedef logic [SlotBits-1:0]  slot_t;
    typedef logic [CountBits-1:0] count_t;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_EXTRACT  = 2'd1,
        CMD_DECREASE = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INCREASE = 3'd2,
        ST_FULL     = 3'd3,
        ST_KEY      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC_RD,
        S_DEC_CHK,
        S_EXT_RD,
        S_EXT_MOVE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;
endpackage

@@ rtl/indexed_min_heap_unit.sv @@
// Indexed min-heap unit: heap slots and key position map in on-chip memories.
// Depends on rtl/imh_pkg.sv and rtl/indexed_min_heap_unit_assert.svh.
// Errors and no-ops go straight to the response state; other commands walk the heap
// one level at a time. One request at a time, the next taken in the cycle after the
// response is loaded into the output register.
// Each sift level passes through a read state and then a compare-and-write state.
// Reset clears the count and the presence bits at once; memories hold no reset.
module indexed_min_heap_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // command[1:0], key[9:2], priority_req[40:10], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // status[2:0], out_key[10:3], out_priority[41:11],
                                  // count[50:42], zero
);
    import imh_pkg::*;
    `include "indexed_min_heap_unit_assert.svh"

    // Heap slot memory holds {key, priority}; position memory maps key to slot.
    logic [KeyBits+PrioBits-1:0] heap_mem [Capacity];
    slot_t                       pos_mem  [NumKeys];
    logic [NumKeys-1:0]          present_reg, present_next;

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    cmd_t    cmd_reg, cmd_next;
    key_t    key_reg, key_next;
    prio_t   prio_reg, prio_next;
    slot_t   idx_reg, idx_next;
    prio_t   cur_prio_reg, cur_prio_next;
    key_t    cur_key_reg, cur_key_next;
    status_t status_reg, status_next;
    key_t    okey_reg, okey_next;
    prio_t   oprio_reg, oprio_next;
    logic    out_valid_reg, out_valid_next;
    logic [55:0] m_data_reg, m_data_next;

    // Two read ports and two write ports on the heap memory; one read port and two write ports on the position memory.
    slot_t rd_a_addr, rd_b_addr;
    logic [KeyBits+PrioBits-1:0] rd_a_reg, rd_b_reg;
    key_t  pos_rd_addr;
    slot_t pos_rd_reg;
    logic  hw_en, hw2_en, pw_en, pw2_en;
    slot_t hw_addr, hw2_addr, pw_data, pw2_data;
    key_t  pw_addr, pw2_addr;
    logic [KeyBits+PrioBits-1:0] hw_data, hw2_data;

    always_ff @(posedge aclk) begin
        rd_a_reg   <= heap_mem[rd_a_addr];
        rd_b_reg   <= heap_mem[rd_b_addr];
        pos_rd_reg <= pos_mem[pos_rd_addr];
        if (hw_en) begin
            heap_mem[hw_addr] <= hw_data;
        end
        if (hw2_en) begin
            heap_mem[hw2_addr] <= hw2_data;
        end
        if (pw_en) begin
            pos_mem[pw_addr] <= pw_data;
        end
        if (pw2_en) begin
            pos_mem[pw2_addr] <= pw2_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        prio_reg     <= prio_next;
        idx_reg      <= idx_next;
        cur_prio_reg <= cur_prio_next;
        cur_key_reg  <= cur_key_next;
        status_reg   <= status_next;
        okey_reg     <= okey_next;
        oprio_reg    <= oprio_next;
        m_data_reg   <= m_data_next;
    end

    cmd_t  in_cmd;
    key_t  in_key;
    prio_t in_prio;
    assign in_cmd  = cmd_t'(s_tdata[1:0]);
    assign in_key  = s_tdata[9:2];
    assign in_prio = s_tdata[40:10];

    slot_t parent_idx, left_idx, right_idx;
    logic [SlotBits:0] left_full;
    assign parent_idx = slot_t'((idx_reg - slot_t'(1)) >> 1);
    assign left_full  = {idx_reg, 1'b1};
    assign left_idx   = left_full[SlotBits-1:0];
    assign right_idx  = left_idx + slot_t'(1);

    prio_t a_prio, b_prio;
    key_t  a_key, b_key;
    assign a_prio = rd_a_reg[PrioBits-1:0];
    assign a_key  = rd_a_reg[KeyBits+PrioBits-1:PrioBits];
    assign b_prio = rd_b_reg[PrioBits-1:0];
    assign b_key  = rd_b_reg[KeyBits+PrioBits-1:PrioBits];

    logic l_ok, r_ok, pick_l, pick_r;
    prio_t min_lp;
    assign l_ok   = count_t'(left_full) < count_reg;
    assign r_ok   = count_t'(left_full) + count_t'(1) < count_reg;
    assign pick_l = l_ok && (a_prio < cur_prio_reg);
    assign min_lp = pick_l ? a_prio : cur_prio_reg;
    assign pick_r = r_ok && (b_prio < min_lp);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        present_next   = present_reg;
        out_valid_next = out_valid_reg;
        m_data_next    = m_data_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        prio_next      = prio_reg;
        idx_next       = idx_reg;
        cur_prio_next  = cur_prio_reg;
        cur_key_next   = cur_key_reg;
        status_next    = status_reg;
        okey_next      = okey_reg;
        oprio_next     = oprio_reg;
        rd_a_addr      = idx_reg;
        rd_b_addr      = idx_reg;
        pos_rd_addr    = key_reg;
        hw_en = 1'b0; hw_addr = idx_reg; hw_data = {cur_key_reg, cur_prio_reg};
        hw2_en = 1'b0; hw2_addr = idx_reg; hw2_data = {cur_key_reg, cur_prio_reg};
        pw_en = 1'b0; pw_addr = cur_key_reg; pw_data = idx_reg;
        pw2_en = 1'b0; pw2_addr = cur_key_reg; pw2_data = idx_reg;
        s_tready = 1'b0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next    = in_cmd;
                    key_next    = in_key;
                    prio_next   = in_prio;
                    status_next = ST_OK;
                    okey_next   = '0;
                    oprio_next  = '0;
                    pos_rd_addr = in_key;
                    rd_a_addr   = '0;
                    state_next  = S_DONE;
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (count_reg >= count_t'(Capacity)) begin
                                status_next = ST_FULL;
                            end else if (present_reg[in_key]) begin
                                status_next = ST_KEY;
                            end else begin
                                present_next[in_key] = 1'b1;
                                count_next    = count_reg + count_t'(1);
                                idx_next      = slot_t'(count_reg);
                                cur_prio_next = in_prio;
                                cur_key_next  = in_key;
                                state_next    = S_UP_RD;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rd_b_addr  = slot_t'(count_reg - count_t'(1));
                                count_next = count_reg - count_t'(1);
                                state_next = S_EXT_RD;
                            end
                        end
                        CMD_DECREASE: begin
                            if (!present_reg[in_key]) begin
                                status_next = ST_KEY;
                            end else begin
                                state_next = S_DEC_RD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DEC_RD: begin
                rd_a_addr  = pos_rd_reg;
                idx_next   = pos_rd_reg;
                state_next = S_DEC_CHK;
            end
            S_DEC_CHK: begin
                if (prio_reg > a_prio) begin
                    status_next = ST_INCREASE;
                    state_next  = S_DONE;
                end else begin
                    cur_prio_next = prio_reg;
                    cur_key_next  = key_reg;
                    state_next    = S_UP_RD;
                end
            end
            S_EXT_RD: begin
                okey_next  = a_key;
                oprio_next = a_prio;
                present_next[a_key] = 1'b0;
                cur_key_next  = b_key;
                cur_prio_next = b_prio;
                idx_next      = '0;
                state_next    = (count_reg == '0) ? S_DONE : S_EXT_MOVE;
            end
            S_EXT_MOVE: begin
                rd_a_addr  = left_idx;
                rd_b_addr  = right_idx;
                state_next = S_DN_CMP;
            end
            S_UP_RD: begin
                rd_a_addr = parent_idx;
                if (idx_reg == '0) begin
                    hw_en = 1'b1;
                    pw_en = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (a_prio > cur_prio_reg) begin
                    hw_en    = 1'b1;
                    hw_data  = rd_a_reg;
                    pw_en    = 1'b1;
                    pw_addr  = a_key;
                    pw_data  = idx_reg;
                    idx_next = parent_idx;
                    state_next = S_UP_RD;
                end else begin
                    hw_en = 1'b1;
                    pw_en = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_RD: begin
                rd_a_addr  = left_idx;
                rd_b_addr  = right_idx;
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                hw_en = 1'b1;
                pw_en = 1'b1;
                pw_addr = (pick_r ? b_key : a_key);
                if (pick_r || pick_l) begin
                    hw_data  = pick_r ? rd_b_reg : rd_a_reg;
                    idx_next = pick_r ? right_idx : left_idx;
                    state_next = S_DN_RD;
                end else begin
                    pw_addr  = cur_key_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    m_data_next    = {5'd0, count_reg, oprio_reg, okey_reg, status_reg};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;

    `IMH_ASSERT_IMPL(a_count_cap, aclk, aresetn, count_reg <= count_t'(Capacity))
    `IMH_ASSERT_IMPL(a_busy_no_ready, aclk, aresetn, (state_reg != S_IDLE) |-> !s_tready)
    `IMH_ASSERT_NEXT(a_done_out, aclk, aresetn,
        (state_reg == S_DONE) && (!out_valid_reg || m_tready), m_tvalid)
    `IMH_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready,
        state_reg != S_IDLE)
endmodule
